>>> src/rtc_pkg.sv
`timescale 1ns / 1ps

package rtc_pkg;

  localparam int unsigned InBytes  = 6;
  localparam int unsigned OutBytes = 6;

  // Reset time and date: 12:30:00 on 1 January 2000.
  localparam logic [7:0]  TpsReset    = 8'd100;
  localparam logic [5:0]  SecReset    = 6'd0;
  localparam logic [5:0]  MinReset    = 6'd30;
  localparam logic [4:0]  HourReset   = 5'd12;
  localparam logic [4:0]  DayReset    = 5'd1;
  localparam logic [3:0]  MonthReset  = 4'd1;
  localparam logic [15:0] YearReset   = 16'd2000;

  localparam logic [6:0]  SecsPerMin  = 7'd60;
  localparam logic [6:0]  MinsPerHour = 7'd60;
  localparam logic [5:0]  HoursPerDay = 6'd24;
  localparam logic [3:0]  LastMonth   = 4'd12;

  // Multiplicative inverse of 25 modulo 2^16, and the largest product that
  // marks a multiple of 25.
  localparam logic [15:0] Inv25       = 16'd23593;
  localparam logic [15:0] Div25Limit  = 16'd2621;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

endpackage

>>> src/rtc_date_adv.sv
`timescale 1ns / 1ps

module rtc_date_adv (
  input  rtc_pkg::date_t cur,
  output rtc_pkg::date_t nxt
);
  import rtc_pkg::*;

  logic [15:0] prod;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;
  logic [4:0]  mlen;
  logic [5:0]  d;

  // Gregorian leap test: divisible by 4, and a century only if also by 400.
  // The product only matters modulo 2^16.
  assign prod  = cur.year * Inv25;
  assign div4  = (cur.year[1:0] == 2'd0);
  assign div16 = (cur.year[3:0] == 4'd0);
  assign div25 = (prod <= Div25Limit);
  assign leap  = div4 && (!div25 || div16);

  always_comb begin
    case (cur.month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: mlen = 5'd31;
      4'd2:    mlen = leap ? 5'd29 : 5'd28;
      default: mlen = 5'd30;
    endcase
  end

  always_comb begin
    d   = {1'b0, cur.day} + 6'd1;
    nxt = cur;
    if (d > {1'b0, mlen}) begin
      nxt.day = 5'd1;
      if (cur.month >= LastMonth) begin
        nxt.month = 4'd1;
        nxt.year  = cur.year + 16'd1;
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end else begin
      nxt.day = d[4:0];
    end
  end

endmodule

>>> src/rtc_calendar_tick_core.sv
`timescale 1ns / 1ps

// Real-time clock and Gregorian calendar advanced by tick beats.
// Input stream: each beat is either a tick (tuser = 0) or a load of the
// time and date carried in tdata (tuser = 1). Every input beat produces
// exactly one output beat giving the time and date after that beat, with
// flags for a completed second and a completed minute.
// Configuration: cfg_data sets the number of ticks in one second; a value
// of zero behaves as one. It is always ready and should only be written
// while no beats are in flight.
// An accepted beat waits in the input register and passes the roll-over
// logic into the result register once that register is free or being read.
// Throughput is one beat per cycle while the output is not stalled, as the
// time and date registers take one update per beat.
// When the output is stalled the result register holds its beat, the input
// register still takes one more beat, and s_axis_tready then falls until
// the output drains.
// Reset (rst, synchronous, active high) clears both stages, sets the clock
// to 12:30:00 on 1 January 2000 and the ticks per second to 100.
module rtc_calendar_tick_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data,      // ticks per second
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // load_hour, load_minute, load_second, load_day, load_month, load_year
  input  logic [rtc_pkg::InBytes*8-1:0]   s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cur_hour, cur_minute, cur_second, cur_day, cur_month, cur_year
  output logic [rtc_pkg::OutBytes*8-1:0]  m_axis_tdata,
  output logic [1:0]                      m_axis_tuser   // second_pulse, minute_pulse
);
  import rtc_pkg::*;

  // Configuration register.
  logic [7:0]  tps;

  // Input register.
  logic        in_valid;
  logic        in_load;
  logic [41:0] in_data;

  // Time and date.
  logic [7:0]  tick_count;
  logic [5:0]  seconds;
  logic [5:0]  minutes;
  logic [4:0]  hours;
  date_t       date;

  // Result register.
  logic        res_valid;
  logic [41:0] res_data;
  logic        res_sec;
  logic        res_min;

  logic        out_ready;
  logic        adv;
  date_t       date_inc;

  logic [8:0]  tick_sum;
  logic [6:0]  sec_sum;
  logic [6:0]  min_sum;
  logic [5:0]  hour_sum;
  logic        sec_done;
  logic        min_done;
  logic        hour_done;
  logic        day_done;

  logic [7:0]  tick_count_next;
  logic [5:0]  seconds_next;
  logic [5:0]  minutes_next;
  logic [4:0]  hours_next;
  date_t       date_next;
  logic        sec_pulse_next;
  logic        min_pulse_next;

  assign cfg_ready     = 1'b1;
  assign out_ready     = !res_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_ready;
  assign adv           = in_valid && out_ready;

  rtc_date_adv u_date_adv (
    .cur (date),
    .nxt (date_inc)
  );

  // Carry chain from the sub-second count up to the date, or a load of the time and date.
  always_comb begin
    tick_sum  = {1'b0, tick_count} + 9'd1;
    sec_sum   = {1'b0, seconds} + 7'd1;
    min_sum   = {1'b0, minutes} + 7'd1;
    hour_sum  = {1'b0, hours} + 6'd1;
    sec_done  = (tick_sum >= {1'b0, tps});
    min_done  = sec_done && (sec_sum >= SecsPerMin);
    hour_done = min_done && (min_sum >= MinsPerHour);
    day_done  = hour_done && (hour_sum >= HoursPerDay);

    if (in_load) begin
      tick_count_next = 8'd0;
      hours_next      = in_data[4:0];
      minutes_next    = in_data[10:5];
      seconds_next    = in_data[16:11];
      date_next.day   = in_data[21:17];
      date_next.month = in_data[25:22];
      date_next.year  = in_data[41:26];
      sec_pulse_next  = 1'b0;
      min_pulse_next  = 1'b0;
    end else begin
      tick_count_next = sec_done ? 8'd0 : tick_sum[7:0];
      seconds_next    = seconds;
      minutes_next    = minutes;
      hours_next      = hours;
      date_next       = day_done ? date_inc : date;
      if (sec_done) begin
        seconds_next = min_done ? 6'd0 : sec_sum[5:0];
      end
      if (min_done) begin
        minutes_next = hour_done ? 6'd0 : min_sum[5:0];
      end
      if (hour_done) begin
        hours_next = day_done ? 5'd0 : hour_sum[4:0];
      end
      sec_pulse_next  = sec_done;
      min_pulse_next  = min_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TpsReset;
    end else if (cfg_valid && cfg_ready) begin
      tps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_load <= s_axis_tuser[0];
      in_data <= s_axis_tdata[41:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 8'd0;
      seconds    <= SecReset;
      minutes    <= MinReset;
      hours      <= HourReset;
      date.day   <= DayReset;
      date.month <= MonthReset;
      date.year  <= YearReset;
    end else if (adv) begin
      tick_count <= tick_count_next;
      seconds    <= seconds_next;
      minutes    <= minutes_next;
      hours      <= hours_next;
      date       <= date_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= {date_next.year, date_next.month, date_next.day,
                   seconds_next, minutes_next, hours_next};
      res_sec  <= sec_pulse_next;
      res_min  <= min_pulse_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{(OutBytes*8-42){1'b0}}, res_data};
  assign m_axis_tuser  = {res_min, res_sec};

  // A minute can only complete on a tick that also completes a second.
  a_min_needs_sec : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_min && !res_sec))
    else $error("minute flag without second flag");

  // A completed minute leaves the seconds at zero.
  a_min_zero_sec : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_min) |-> (res_data[16:11] == 6'd0))
    else $error("minute completed but seconds not zero");

  // While the output is stalled a waiting input beat is neither lost nor changed.
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_ready) |=> (in_valid && $stable(in_data) && $stable(in_load)))
    else $error("input register changed under stall");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeLoad = 1'b1;
  localparam logic [3:0] February = 4'd2;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        sec_pulse;
    logic        min_pulse;
  } clock_reading_t;

  // Keeps its own copy of the clock and calendar, predicts the reading that
  // each input beat produces and checks the output beats against them.
  class calendar_scoreboard;
    logic [7:0]  rate;
    logic [7:0]  sub_count;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [15:0] yr;
    clock_reading_t expected_readings[$];
    int mismatches;
    int ticks_seen;
    int loads_seen;
    int second_marks;
    int minute_marks;
    int rate_writes;

    function new();
      rate = rtc_pkg::TpsReset;
      sub_count = 8'd0;
      sec = rtc_pkg::SecReset;
      min = rtc_pkg::MinReset;
      hr = rtc_pkg::HourReset;
      dom = rtc_pkg::DayReset;
      mon = rtc_pkg::MonthReset;
      yr = rtc_pkg::YearReset;
      mismatches = 0;
      ticks_seen = 0;
      loads_seen = 0;
      second_marks = 0;
      minute_marks = 0;
      rate_writes = 0;
    endfunction

    function void set_rate(logic [7:0] value);
      rate = value;
      rate_writes++;
    endfunction

    function int month_days(logic [3:0] m, logic [15:0] y);
      logic leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
        February: return leap ? 29 : 28;
        default: return 30;
      endcase
    endfunction

    function void note_beat(logic mode, logic [47:0] data);
      clock_reading_t r;
      int t, s, m, h, d;
      r.sec_pulse = 1'b0;
      r.min_pulse = 1'b0;
      if (mode == ModeLoad) begin
        hr = data[4:0];
        min = data[10:5];
        sec = data[16:11];
        dom = data[21:17];
        mon = data[25:22];
        yr = data[41:26];
        sub_count = 8'd0;
        loads_seen++;
      end else begin
        ticks_seen++;
        t = sub_count + 1;
        // A rate of zero is always reached, so it behaves as one.
        if (t >= rate) begin
          sub_count = 8'd0;
          r.sec_pulse = 1'b1;
          s = sec + 1;
          if (s >= 60) begin
            s = 0;
            r.min_pulse = 1'b1;
            m = min + 1;
            if (m >= 60) begin
              m = 0;
              h = hr + 1;
              if (h >= 24) begin
                h = 0;
                d = dom + 1;
                if (d > month_days(mon, yr)) begin
                  d = 1;
                  if (mon >= 4'd12) begin
                    mon = 4'd1;
                    yr = yr + 16'd1;
                  end else begin
                    mon = mon + 4'd1;
                  end
                end
                dom = d[4:0];
              end
              hr = h[4:0];
            end
            min = m[5:0];
          end
          sec = s[5:0];
        end else begin
          sub_count = t[7:0];
        end
      end
      r.hour = hr;
      r.minute = min;
      r.second = sec;
      r.day = dom;
      r.month = mon;
      r.year = yr;
      if (r.sec_pulse) second_marks++;
      if (r.min_pulse) minute_marks++;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_reading(logic [47:0] data, logic [1:0] flags);
      clock_reading_t e;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Output beat with no reading outstanding: data %h flags %b", data, flags);
      end else begin
        e = expected_readings.pop_front();
        compare_field("hour", e.hour, data[4:0]);
        compare_field("minute", e.minute, data[10:5]);
        compare_field("second", e.second, data[16:11]);
        compare_field("day", e.day, data[21:17]);
        compare_field("month", e.month, data[25:22]);
        compare_field("year", e.year, data[41:26]);
        compare_field("second_pulse", e.sec_pulse, flags[0]);
        compare_field("minute_pulse", e.min_pulse, flags[1]);
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [rtc_pkg::InBytes*8-1:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [rtc_pkg::OutBytes*8-1:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  calendar_scoreboard sb = new();
  logic source_steady = 1'b0;
  logic sink_steady = 1'b0;
  int   sink_hold = 0;
  int   idle_cycles = 0;
  int   errors = 0;

  rtc_calendar_tick_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  function int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Every handshake is sampled at the clock edge, before any of the
  // nonblocking updates made at that edge land.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_rate(cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_reading(m_axis_tdata, m_axis_tuser);
    end
  end

  // Output side back-pressure: random stalls, no new ones started while sink_steady is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 99) < 25) sink_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no beat accepted for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function logic [47:0] pack_load(int h, int m, int s, int d, int mo, int y);
    logic [47:0] data;
    data = {6'b0, y[15:0], mo[3:0], d[4:0], s[5:0], m[5:0], h[4:0]};
    return data;
  endfunction

  // A load aimed just short of a roll-over, now and then with values out of
  // range, so that short tick bursts reach the day, month and year carries.
  function logic [47:0] edge_load();
    int h, m, s, d, mo, y, r;
    r = $urandom_range(0, 99);
    h = (r < 70) ? 23 : (r < 90) ? $urandom_range(0, 23) : $urandom_range(0, 31);
    r = $urandom_range(0, 99);
    m = (r < 70) ? 59 : (r < 90) ? $urandom_range(0, 59) : $urandom_range(0, 63);
    r = $urandom_range(0, 99);
    s = (r < 70) ? $urandom_range(55, 59) : (r < 90) ? $urandom_range(0, 59)
                                                     : $urandom_range(0, 63);
    mo = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    case ($urandom_range(0, 7))
      0: y = 1900;
      1: y = 2000;
      2: y = 2100;
      3: y = 2024;
      4: y = 2023;
      5: y = 65535;
      default: y = $urandom_range(0, 65535);
    endcase
    r = $urandom_range(0, 99);
    if (r < 60) d = sb.month_days(mo[3:0], y[15:0]) - $urandom_range(0, 1);
    else if (r < 85) d = $urandom_range(1, 31);
    else d = $urandom_range(0, 31);
    return pack_load(h, m, s, d, mo, y);
  endfunction

  task automatic send_beat(logic mode, logic [47:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!source_steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int count);
    logic [47:0] junk;
    repeat (count) begin
      junk = 48'({$urandom, $urandom});
      junk[47:42] = 6'b0;
      send_beat(ModeTick, junk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_rate(logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load then one tick, checking a single roll-over.
  task automatic load_and_tick(int h, int m, int s, int d, int mo, int y);
    send_beat(ModeLoad, pack_load(h, m, s, d, mo, y));
    send_ticks(1);
  endtask

  task automatic run_phase(logic [7:0] rate, int beats);
    int sent, r, burst, span;
    write_rate(rate);
    span = (rate <= 8'd3) ? 70 : 2 * rate;
    sent = 0;
    while (sent < beats) begin
      source_steady = ($urandom_range(0, 9) == 0);
      sink_steady <= ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      burst = $urandom_range(1, span);
      if (r < 70) begin
        send_beat(ModeLoad, edge_load());
        sent++;
      end else if (r < 85) begin
        send_beat(ModeLoad, {6'b0, 16'($urandom_range(0, 65535)),
                             26'($urandom_range(0, 67108863))});
        sent++;
        burst = $urandom_range(1, 5);
      end
      // Keep the phase close to its share of beats.
      if (burst > beats - sent) burst = beats - sent;
      send_ticks(burst);
      sent += burst;
      // Hold the input back now and then until every reading has come out.
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state at the default rate, then single roll-overs at one tick
    // per second.
    send_ticks(2);
    write_rate(8'd1);
    load_and_tick(23, 59, 59, 31, 12, 65535);
    load_and_tick(23, 59, 59, 28, 2, 2000);
    load_and_tick(23, 59, 59, 29, 2, 2000);
    load_and_tick(23, 59, 59, 28, 2, 1900);
    load_and_tick(23, 59, 59, 28, 2, 2024);
    load_and_tick(23, 59, 59, 31, 1, 2023);
    load_and_tick(23, 59, 59, 30, 4, 2023);
    load_and_tick(31, 63, 63, 31, 15, 5);
    load_and_tick(23, 59, 59, 0, 0, 2001);
    load_and_tick(0, 0, 0, 1, 1, 0);
    load_and_tick(0, 58, 59, 31, 13, 100);

    // A high rate followed by a low one leaves the sub-second count above
    // the new rate; a rate of zero acts as one.
    run_phase(8'd1, 300);
    run_phase(8'd255, 300);
    run_phase(8'd2, 250);
    run_phase(8'd0, 200);
    run_phase(8'd7, 200);
    run_phase(8'($urandom_range(1, 255)), 150);

    drain();
    repeat (10) @(posedge clk);
    errors = sb.mismatches;
    if (sb.pending() != 0) begin
      $display("%0d expected readings never came out", sb.pending());
      errors += sb.pending();
    end
    $display("Covered %0d ticks and %0d loads over %0d rate settings.",
             sb.ticks_seen, sb.loads_seen, sb.rate_writes);
    $display("Saw %0d completed seconds and %0d completed minutes; %0d mismatches.",
             sb.second_marks, sb.minute_marks, sb.mismatches);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
